[rtl/core/trmz_pkg.sv]
// shared types, codes and arithmetic helpers of the triangle rasterizer
package trmz_pkg;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] SLOT_NONE = 2'd3;

   localparam logic CSR_MSAA_ENABLE = 1'b0;

   localparam logic [15:0] DEPTH_FAR = 16'hFFFF;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_STEP,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  slot;
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] z;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AREA,
      ST_DIV,
      ST_SAMPLE,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   function automatic logic signed [26:0] edge_fn(input logic [11:0] ax, input logic [11:0] ay,
                                                  input logic [11:0] bx, input logic [11:0] by,
                                                  input logic [11:0] px, input logic [11:0] py);
      logic signed [12:0] ex, ey, dx, dy;
      logic signed [25:0] m0, m1;
      ex = $signed({1'b0, bx}) - $signed({1'b0, ax});
      ey = $signed({1'b0, by}) - $signed({1'b0, ay});
      dx = $signed({1'b0, px}) - $signed({1'b0, ax});
      dy = $signed({1'b0, py}) - $signed({1'b0, ay});
      m0 = ex * dy;
      m1 = dx * ey;
      return $signed({m0[25], m0}) - $signed({m1[25], m1});
   endfunction

   function automatic logic [11:0] min3(input logic [11:0] a, input logic [11:0] b,
                                        input logic [11:0] c);
      logic [11:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic [11:0] max3(input logic [11:0] a, input logic [11:0] b,
                                        input logic [11:0] c);
      logic [11:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage

[rtl/core/trmz_if.sv]
// request and response channel interfaces
interface trmz_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [1:0]  vertex_slot;
   logic [11:0] vertex_x;
   logic [11:0] vertex_y;
   logic [15:0] vertex_depth;
   logic [7:0]  color_red;
   logic [7:0]  color_green;
   logic [7:0]  color_blue;

   modport source (output valid, req_type, vertex_slot, vertex_x, vertex_y, vertex_depth,
                   color_red, color_green, color_blue, input ready);
   modport sink (input valid, req_type, vertex_slot, vertex_x, vertex_y, vertex_depth,
                 color_red, color_green, color_blue, output ready);
endinterface

interface trmz_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [15:0] frame_index;
   logic [15:0] pixel_depth;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic        write_enable;
   logic        last_pixel;

   modport source (output valid, pixel_x, pixel_y, frame_index, pixel_depth, out_red,
                   out_green, out_blue, write_enable, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, frame_index, pixel_depth, out_red,
                 out_green, out_blue, write_enable, last_pixel, output ready);
endinterface

[rtl/core/trmz_front.sv]
// request intake: decodes requests, drops ignored ones and queues commands
module trmz_front
   import trmz_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   trmz_req_if.sink req,
   output cmd_type cmd,
   output logic    cmd_valid,
   input  logic    cmd_pop
);

   cmd_type    ent_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       xfer, useful, push, pop;
   cmd_type    dec;

   assign req.ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign xfer = req.valid && req.ready;

   always_comb begin
      dec.slot  = req.vertex_slot;
      dec.x     = req.vertex_x;
      dec.y     = req.vertex_y;
      dec.z     = req.vertex_depth;
      dec.red   = req.color_red;
      dec.green = req.color_green;
      dec.blue  = req.color_blue;
      dec.op    = OP_STEP;
      useful    = 1'b0;
      unique case (req.req_type)
         REQ_LOAD: begin
            dec.op = OP_LOAD;
            useful = (req.vertex_slot != SLOT_NONE);
         end
         REQ_STEP: begin
            dec.op = OP_STEP;
            useful = 1'b1;
         end
         REQ_CLEAR: begin
            dec.op = OP_CLEAR;
            useful = 1'b1;
         end
         default: useful = 1'b0;
      endcase
   end

   assign push = xfer && useful;
   assign pop  = cmd_pop && cmd_valid;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

[rtl/core/trmz_div.sv]
// radix-2 restoring divider for the area reciprocal, 2^31 / area
module trmz_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [25:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [25:0] dvs_ff, dvs_in;
   logic [25:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [27:0] diff;

   assign diff = {1'b0, rem_ff, quo_ff[31]} - {2'b00, dvs_ff};

   always_comb begin
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvs_in = divisor;
         rem_in = '0;
         quo_in = 32'h8000_0000;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (!diff[27]) begin
            rem_in = diff[25:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[24:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/trmz_back.sv]
// execution side: triangle setup, sample pipeline, depth store and result register
module trmz_back
   import trmz_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 256
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      cmd_valid,
   output logic      cmd_pop,
   input  logic      msaa,
   trmz_rsp_if.source rsp
);

   localparam logic [31:0] WIDTH32  = 32'(SCREEN_WIDTH);
   localparam logic [31:0] HEIGHT32 = 32'(SCREEN_HEIGHT);

   state_type state_ff, state_in;
   logic [11:0] vx_ff [3], vx_in [3];
   logic [11:0] vy_ff [3], vy_in [3];
   logic [15:0] vz_ff [3], vz_in [3];
   logic [7:0]  red_ff, red_in, grn_ff, grn_in, blu_ff, blu_in;
   logic [7:0]  xmin_ff, xmin_in, ymin_ff, ymin_in, xmax_ff, xmax_in, ymax_ff, ymax_in;
   logic [31:0] rec_ff, rec_in;
   logic [7:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic        active_ff, active_in;
   logic [15:0] clr_addr_ff, clr_addr_in;
   logic [1:0]  sidx_ff, sidx_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] mind_ff, mind_in;

   logic               p1_v_ff, p2_v_ff, p3_v_ff;
   logic               in2_ff, in2_in, in3_ff;
   logic signed [26:0] e_ff [3], e_in [3];
   logic [15:0]        w_ff [3], w_in [3];
   logic [31:0]        pz_ff [3], pz_in [3];

   logic        ov_ff, ov_in;
   logic [7:0]  o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic [15:0] o_idx_ff, o_idx_in, o_dep_ff, o_dep_in;
   logic [7:0]  o_r_ff, o_r_in, o_g_ff, o_g_in, o_b_ff, o_b_in;
   logic        o_we_ff, o_we_in, o_last_ff, o_last_in;

   logic [15:0] depth_mem [65536];
   logic [15:0] rd_ff;
   logic        mem_we;
   logic [15:0] mem_waddr, mem_wdata;

   logic        div_start, div_done;
   logic [31:0] div_q;
   logic signed [26:0] area_c;
   logic [11:0] bx_min, by_min, bx_max, by_max;
   logic [3:0]  ox, oy;
   logic [11:0] px, py;
   logic [57:0] wprod [3];
   logic [33:0] zsum;
   logic [15:0] zval;
   logic        onscreen, last, we, out_free, load_out;
   logic [31:0] idx_full;
   logic [15:0] idx;
   logic [2:0]  scale;
   logic [10:0] sr, sg, sb;
   logic [1:0]  sidx_last;

   trmz_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (area_c[25:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign area_c = edge_fn(vx_ff[0], vy_ff[0], vx_ff[1], vy_ff[1], vx_ff[2], vy_ff[2]);
   assign bx_min = min3(vx_ff[0], vx_ff[1], vx_ff[2]);
   assign by_min = min3(vy_ff[0], vy_ff[1], vy_ff[2]);
   assign bx_max = max3(vx_ff[0], vx_ff[1], vx_ff[2]);
   assign by_max = max3(vy_ff[0], vy_ff[1], vy_ff[2]);

   // sample position, quarter offsets or pixel center
   assign ox = msaa ? (sidx_ff[0] ? 4'd12 : 4'd4) : 4'd8;
   assign oy = msaa ? (sidx_ff[1] ? 4'd12 : 4'd4) : 4'd8;
   assign px = {cur_x_ff, 4'b0000} + {8'd0, ox};
   assign py = {cur_y_ff, 4'b0000} + {8'd0, oy};
   assign sidx_last = msaa ? 2'd3 : 2'd0;

   always_comb begin
      e_in[0] = edge_fn(vx_ff[1], vy_ff[1], vx_ff[2], vy_ff[2], px, py);
      e_in[1] = edge_fn(vx_ff[2], vy_ff[2], vx_ff[0], vy_ff[0], px, py);
      e_in[2] = edge_fn(vx_ff[0], vy_ff[0], vx_ff[1], vy_ff[1], px, py);
      in2_in = (e_ff[0] > 0) && (e_ff[1] > 0) && (e_ff[2] > 0);
      for (int i = 0; i < 3; i++) begin
         wprod[i] = {32'd0, e_ff[i][25:0]} * {26'd0, rec_ff};
         w_in[i] = wprod[i][30:15];
         pz_in[i] = {16'd0, w_ff[i]} * {16'd0, vz_ff[i]};
      end
      zsum = {2'b00, pz_ff[0]} + {2'b00, pz_ff[1]} + {2'b00, pz_ff[2]};
      zval = (zsum[33:32] != 2'b00) ? DEPTH_FAR : zsum[31:16];
   end

   assign onscreen = ({24'd0, cur_x_ff} < WIDTH32) && ({24'd0, cur_y_ff} < HEIGHT32);
   assign idx_full = (HEIGHT32 - 32'd1 - {24'd0, cur_y_ff}) * WIDTH32 + {24'd0, cur_x_ff};
   assign idx = onscreen ? idx_full[15:0] : 16'd0;
   assign we = (cnt_ff != 3'd0) && onscreen && (mind_ff < rd_ff);
   assign last = (cur_x_ff == xmax_ff) && (cur_y_ff == ymax_ff);
   assign scale = msaa ? cnt_ff : 3'd4;
   assign sr = red_ff * scale;
   assign sg = grn_ff * scale;
   assign sb = blu_ff * scale;
   assign out_free = !ov_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      vz_in = vz_ff;
      red_in = red_ff;
      grn_in = grn_ff;
      blu_in = blu_ff;
      xmin_in = xmin_ff;
      ymin_in = ymin_ff;
      xmax_in = xmax_ff;
      ymax_in = ymax_ff;
      rec_in = rec_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      active_in = active_ff;
      clr_addr_in = clr_addr_ff;
      sidx_in = sidx_ff;
      cnt_in = cnt_ff;
      mind_in = mind_ff;
      cmd_pop = 1'b0;
      div_start = 1'b0;
      mem_we = 1'b0;
      mem_waddr = idx;
      mem_wdata = mind_ff;
      load_out = 1'b0;

      if (p3_v_ff && in3_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (zval < mind_ff) begin
            mind_in = zval;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = DEPTH_FAR;
            clr_addr_in = clr_addr_ff + 16'd1;
            if (clr_addr_ff == 16'hFFFF) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_LOAD: begin
                     vx_in[cmd.slot] = cmd.x;
                     vy_in[cmd.slot] = cmd.y;
                     vz_in[cmd.slot] = cmd.z;
                     if (cmd.slot == 2'd0) begin
                        red_in = cmd.red;
                        grn_in = cmd.green;
                        blu_in = cmd.blue;
                     end
                     if (cmd.slot == 2'd2) begin
                        state_in = ST_AREA;
                     end else begin
                        active_in = 1'b0;
                     end
                  end
                  OP_STEP: begin
                     if (active_ff) begin
                        sidx_in = 2'd0;
                        cnt_in = 3'd0;
                        mind_in = DEPTH_FAR;
                        state_in = ST_SAMPLE;
                     end
                  end
                  OP_CLEAR: begin
                     clr_addr_in = 16'd0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_AREA: begin
            xmin_in = bx_min[11:4];
            ymin_in = by_min[11:4];
            xmax_in = bx_max[11:4];
            ymax_in = by_max[11:4];
            cur_x_in = bx_min[11:4];
            cur_y_in = by_min[11:4];
            if (area_c > 0) begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               rec_in = 32'd0;
               active_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rec_in = div_q;
               active_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SAMPLE: begin
            sidx_in = sidx_ff + 2'd1;
            if (sidx_ff == sidx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff && !p3_v_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               load_out = 1'b1;
               mem_we = we;
               if (last) begin
                  active_in = 1'b0;
               end else if (cur_y_ff < ymax_ff) begin
                  cur_y_in = cur_y_ff + 8'd1;
               end else begin
                  cur_y_in = ymin_ff;
                  cur_x_in = cur_x_ff + 8'd1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ov_in = load_out ? 1'b1 : (rsp.ready ? 1'b0 : ov_ff);
      o_x_in = o_x_ff;
      o_y_in = o_y_ff;
      o_idx_in = o_idx_ff;
      o_dep_in = o_dep_ff;
      o_r_in = o_r_ff;
      o_g_in = o_g_ff;
      o_b_in = o_b_ff;
      o_we_in = o_we_ff;
      o_last_in = o_last_ff;
      if (load_out) begin
         o_x_in = cur_x_ff;
         o_y_in = cur_y_ff;
         o_idx_in = idx;
         o_dep_in = we ? mind_ff : 16'd0;
         o_r_in = we ? sr[9:2] : 8'd0;
         o_g_in = we ? sg[9:2] : 8'd0;
         o_b_in = we ? sb[9:2] : 8'd0;
         o_we_in = we;
         o_last_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= 16'd0;
         active_ff <= 1'b0;
         cur_x_ff <= 8'd0;
         cur_y_ff <= 8'd0;
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= 12'd0;
            vy_ff[i] <= 12'd0;
            vz_ff[i] <= 16'd0;
         end
         red_ff <= 8'd0;
         grn_ff <= 8'd0;
         blu_ff <= 8'd0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         active_ff <= active_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
         red_ff <= red_in;
         grn_ff <= grn_in;
         blu_ff <= blu_in;
         p1_v_ff <= (state_ff == ST_SAMPLE);
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      xmin_ff <= xmin_in;
      ymin_ff <= ymin_in;
      xmax_ff <= xmax_in;
      ymax_ff <= ymax_in;
      rec_ff <= rec_in;
      sidx_ff <= sidx_in;
      cnt_ff <= cnt_in;
      mind_ff <= mind_in;
      e_ff <= e_in;
      in2_ff <= in2_in;
      w_ff <= w_in;
      in3_ff <= in2_ff;
      pz_ff <= pz_in;
      o_x_ff <= o_x_in;
      o_y_ff <= o_y_in;
      o_idx_ff <= o_idx_in;
      o_dep_ff <= o_dep_in;
      o_r_ff <= o_r_in;
      o_g_ff <= o_g_in;
      o_b_ff <= o_b_in;
      o_we_ff <= o_we_in;
      o_last_ff <= o_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= depth_mem[idx];
   end

   assign rsp.valid = ov_ff;
   assign rsp.pixel_x = o_x_ff;
   assign rsp.pixel_y = o_y_ff;
   assign rsp.frame_index = o_idx_ff;
   assign rsp.pixel_depth = o_dep_ff;
   assign rsp.out_red = o_r_ff;
   assign rsp.out_green = o_g_ff;
   assign rsp.out_blue = o_b_ff;
   assign rsp.write_enable = o_we_ff;
   assign rsp.last_pixel = o_last_ff;

   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_DECIDE))
      else $error("depth store written outside clear or decide");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!ov_ff || rsp.ready))
      else $error("result register overwritten before transfer");

   a_pipe_from_issue: assert property (@(posedge clock) disable iff (reset)
      p1_v_ff |-> $past(state_ff == ST_SAMPLE))
      else $error("sample pipeline entered without issue");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside setup");

endmodule

[rtl/core/triangle_raster_msaa_zbuffer.sv]
// top level of the edge-function triangle rasterizer with depth store and 2x2 msaa
// Load vertices 0, 1, 2 (color with vertex 0); loading vertex 2 runs setup, which uses the
// restoring area-reciprocal divider when the area is positive. Each step request while a
// triangle is active produces one pixel result: the samples of a pixel, 4 with msaa_enable
// set and 1 otherwise, pass one at a time through a shared edge, weight and depth pipeline,
// followed by one depth store read-compare-write. A clear request, and the pass that
// follows reset, sweeps the 65536-entry depth store at one entry a cycle, during which no
// further request is executed. Requests are queued two deep.
module triangle_raster_msaa_zbuffer
   import trmz_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   trmz_req_if.sink    req,
   trmz_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic    msaa_ff, msaa_in;
   logic    csr_wr;
   cmd_type cmd;
   logic    cmd_valid, cmd_pop;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign msaa_in = (csr_wr && (paddr[2] == CSR_MSAA_ENABLE)) ? pwdata[0] : msaa_ff;
   assign prdata = (paddr[2] == CSR_MSAA_ENABLE) ? {31'd0, msaa_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         msaa_ff <= 1'b1;
      end else begin
         msaa_ff <= msaa_in;
      end
   end

   trmz_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   trmz_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .msaa      (msaa_ff),
      .rsp       (rsp)
   );

endmodule

[bench/tb_triangle_raster_msaa_zbuffer.sv]
// self-checking bench: directed and random triangles through the rasterizer, checked pixel by pixel
module tb_triangle_raster_msaa_zbuffer;
   import trmz_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]  px;
      logic [7:0]  py;
      logic [15:0] fidx;
      logic [15:0] depth;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        we;
      logic        last;
   } pixel_type;

   localparam int MAX_CYCLES = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   trmz_req_if req_if();
   trmz_rsp_if rsp_if();

   triangle_raster_msaa_zbuffer u_dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cmd_type     pending_cmds[$];
   pixel_type   expected_pixels[$];
   int          mismatches = 0;
   int          pixels_seen = 0;
   int          pixels_written = 0;
   int          triangles = 0;
   int          clears = 0;
   int          item_total = 0;
   longint      cycle = 0;
   bit          no_idle = 1'b0;
   bit          clear_sent = 1'b0;

   // predictor state
   bit          msaa_on = 1'b1;
   logic [11:0] vx[3], vy[3];
   logic [15:0] vz[3];
   logic [23:0] tri_color = '0;
   int          box_xmin, box_ymin, box_xmax, box_ymax;
   longint      recip = 0;
   int          cur_x = 0, cur_y = 0;
   bit          drawing = 1'b0;
   logic [15:0] zbuf[65536];

   function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
      return (bx - ax) * (py - ay) - (px - ax) * (by - ay);
   endfunction

   function automatic int min3i(int a, int b, int c);
      int m;
      m = a < b ? a : b;
      return m < c ? m : c;
   endfunction

   function automatic int max3i(int a, int b, int c);
      int m;
      m = a > b ? a : b;
      return m > c ? m : c;
   endfunction

   task automatic clear_zbuf();
      for (int i = 0; i < 65536; i++) zbuf[i] = DEPTH_FAR;
   endtask

   task automatic predict_pixel(input cmd_type c);
      int          nsamp, cnt, scale;
      longint      mind, px, py, e0, e1, e2, w0, w1, w2, z;
      int          offx[4], offy[4];
      pixel_type   p;
      int          idx;
      offx = '{4, 12, 4, 12};
      offy = '{4, 4, 12, 12};
      if (c.op == OP_CLEAR) begin
         clear_zbuf();
         return;
      end
      if (c.op == OP_LOAD) begin
         if (c.slot == SLOT_NONE) return;
         vx[c.slot] = c.x;
         vy[c.slot] = c.y;
         vz[c.slot] = c.z;
         if (c.slot == 2'd0) tri_color = {c.blue, c.green, c.red};
         if (c.slot == 2'd2) begin
            e0 = edge_val(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
            box_xmin = min3i(vx[0], vx[1], vx[2]) >> 4;
            box_ymin = min3i(vy[0], vy[1], vy[2]) >> 4;
            box_xmax = max3i(vx[0], vx[1], vx[2]) >> 4;
            box_ymax = max3i(vy[0], vy[1], vy[2]) >> 4;
            recip = e0 > 0 ? (64'd1 << 31) / e0 : 0;
            cur_x = box_xmin;
            cur_y = box_ymin;
            drawing = 1'b1;
         end else begin
            drawing = 1'b0;
         end
         return;
      end
      if (c.op != OP_STEP || !drawing) return;
      nsamp = msaa_on ? 4 : 1;
      cnt = 0;
      mind = DEPTH_FAR;
      for (int i = 0; i < nsamp; i++) begin
         px = (cur_x << 4) + (msaa_on ? offx[i] : 8);
         py = (cur_y << 4) + (msaa_on ? offy[i] : 8);
         e0 = edge_val(vx[1], vy[1], vx[2], vy[2], px, py);
         e1 = edge_val(vx[2], vy[2], vx[0], vy[0], px, py);
         e2 = edge_val(vx[0], vy[0], vx[1], vy[1], px, py);
         if (e0 > 0 && e1 > 0 && e2 > 0) begin
            w0 = (e0 * recip) >> 15;
            w1 = (e1 * recip) >> 15;
            w2 = (e2 * recip) >> 15;
            z = (w0 * vz[0] + w1 * vz[1] + w2 * vz[2]) >> 16;
            if (z > DEPTH_FAR) z = DEPTH_FAR;
            if (z < mind) mind = z;
            cnt++;
         end
      end
      // 12-bit q8.4 coordinates always land on the 256x256 screen
      idx = ((255 - cur_y) * 256 + cur_x) & 16'hFFFF;
      p = '{px: cur_x[7:0], py: cur_y[7:0], fidx: idx[15:0], default: '0};
      if (cnt > 0 && mind < zbuf[idx]) begin
         scale = msaa_on ? cnt : 4;
         zbuf[idx] = mind[15:0];
         p.we = 1'b1;
         p.depth = mind[15:0];
         p.red = (tri_color[7:0] * scale) >> 2;
         p.green = (tri_color[15:8] * scale) >> 2;
         p.blue = (tri_color[23:16] * scale) >> 2;
      end
      p.last = (cur_x == box_xmax && cur_y == box_ymax);
      if (p.last) drawing = 1'b0;
      else if (cur_y < box_ymax) cur_y++;
      else begin
         cur_y = box_ymin;
         cur_x++;
      end
      expected_pixels.push_back(p);
   endtask

   // request driver
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycle);
         $display("TEST FAILED");
         $finish;
      end
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_pixel('{op: op_type'(req_if.req_type), slot: req_if.vertex_slot,
                            x: req_if.vertex_x, y: req_if.vertex_y, z: req_if.vertex_depth,
                            red: req_if.color_red, green: req_if.color_green,
                            blue: req_if.color_blue});
         if (!req_if.valid || req_if.ready) begin
            if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 20)) begin
               cmd_type c;
               c = pending_cmds.pop_front();
               req_if.valid <= 1'b1;
               req_if.req_type <= c.op;
               req_if.vertex_slot <= c.slot;
               req_if.vertex_x <= c.x;
               req_if.vertex_y <= c.y;
               req_if.vertex_depth <= c.z;
               req_if.color_red <= c.red;
               req_if.color_green <= c.green;
               req_if.color_blue <= c.blue;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            pixel_type a, e;
            a = '{px: rsp_if.pixel_x, py: rsp_if.pixel_y, fidx: rsp_if.frame_index,
                  depth: rsp_if.pixel_depth, red: rsp_if.out_red, green: rsp_if.out_green,
                  blue: rsp_if.out_blue, we: rsp_if.write_enable, last: rsp_if.last_pixel};
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: x=%0d y=%0d", a.px, a.py);
            end else begin
               e = expected_pixels.pop_front();
               if (e.we) pixels_written++;
               if (a.px !== e.px || a.py !== e.py || a.fidx !== e.fidx ||
                   a.depth !== e.depth || a.red !== e.red || a.green !== e.green ||
                   a.blue !== e.blue || a.we !== e.we || a.last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch exp: x=%0d y=%0d idx=%0d z=%0d rgb=%0d,%0d,%0d we=%b last=%b",
                              e.px, e.py, e.fidx, e.depth, e.red, e.green, e.blue, e.we, e.last);
                     $display("         got: x=%0d y=%0d idx=%0d z=%0d rgb=%0d,%0d,%0d we=%b last=%b",
                              a.px, a.py, a.fidx, a.depth, a.red, a.green, a.blue, a.we, a.last);
                  end
               end
            end
         end
         rsp_if.ready <= no_idle || $urandom_range(0, 99) >= 20;
      end
   end

   task automatic push_cmd(input op_type op, input logic [1:0] slot, input logic [11:0] x,
                           input logic [11:0] y, input logic [15:0] z,
                           input logic [23:0] rgb);
      pending_cmds.push_back('{op: op, slot: slot, x: x, y: y, z: z,
                              red: rgb[7:0], green: rgb[15:8], blue: rgb[23:16]});
      item_total++;
      if (op == OP_CLEAR) begin
         clear_sent = 1'b1;
         clears++;
      end
   endtask

   task automatic push_steps(input int n);
      for (int i = 0; i < n; i++)
         push_cmd(OP_STEP, $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
   endtask

   // loads a triangle and returns its box pixel count
   task automatic push_triangle(input int x0, input int y0, input int x1, input int y1,
                                input int x2, input int y2, output int npix);
      push_cmd(OP_LOAD, 2'd0, x0, y0, $urandom, $urandom);
      push_cmd(OP_LOAD, 2'd1, x1, y1, $urandom, $urandom);
      push_cmd(OP_LOAD, 2'd2, x2, y2, $urandom, $urandom);
      npix = ((max3i(x0, x1, x2) >> 4) - (min3i(x0, x1, x2) >> 4) + 1) *
             ((max3i(y0, y1, y2) >> 4) - (min3i(y0, y1, y2) >> 4) + 1);
      triangles++;
   endtask

   task automatic random_triangle(output int npix);
      int bx, by, spread, xs[3], ys[3], t;
      bx = $urandom_range(0, 4095);
      by = $urandom_range(0, 4095);
      spread = $urandom_range(0, 9) == 0 ? 120 : 40;
      for (int i = 0; i < 3; i++) begin
         xs[i] = bx + $urandom_range(0, spread);
         ys[i] = by + $urandom_range(0, spread);
         if (xs[i] > 4095) xs[i] = 4095;
         if (ys[i] > 4095) ys[i] = 4095;
      end
      // mostly counter-clockwise so that pixels get drawn
      if (edge_val(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]) < 0 &&
          $urandom_range(0, 99) < 85) begin
         t = xs[1]; xs[1] = xs[2]; xs[2] = t;
         t = ys[1]; ys[1] = ys[2]; ys[2] = t;
      end
      push_triangle(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], npix);
   endtask

   task automatic csr_write(input logic value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {CSR_MSAA_ENABLE, 2'b00};
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      msaa_on = value;
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || req_if.valid || expected_pixels.size() > 0)
         @(posedge clock);
      // a clear keeps the block busy without producing a transfer
      repeat (clear_sent ? 70000 : 80) @(posedge clock);
      clear_sent = 1'b0;
   endtask

   initial begin
      int npix, r, clears_left, phase_items;
      req_if.valid = 1'b0;
      req_if.req_type = '0;
      req_if.vertex_slot = '0;
      req_if.vertex_x = '0;
      req_if.vertex_y = '0;
      req_if.vertex_depth = '0;
      req_if.color_red = '0;
      req_if.color_green = '0;
      req_if.color_blue = '0;
      rsp_if.ready = 1'b0;
      clear_zbuf();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, msaa on from reset
      push_steps(1);
      push_cmd(OP_LOAD, SLOT_NONE, 12'hFFF, 12'hFFF, 16'hFFFF, 24'hFFFFFF);
      push_cmd(op_type'(2'd3), 2'd0, '0, '0, '0, '0);
      push_cmd(OP_LOAD, 2'd0, 12'd0, 12'd0, 16'd0, 24'hFFFFFF);
      push_cmd(OP_LOAD, 2'd1, 12'd40, 12'd0, 16'hFFFF, 24'h000000);
      push_cmd(OP_LOAD, 2'd2, 12'd0, 12'd40, 16'h8000, 24'h123456);
      push_steps(9);
      push_triangle(4095, 4095, 4040, 4095, 4095, 4040, npix);
      push_steps(npix);
      push_triangle(0, 0, 0, 40, 40, 0, npix);
      push_steps(npix + 1);
      drain();
      csr_write(1'b0);
      push_triangle(100, 100, 130, 100, 100, 130, npix);
      push_steps(npix);
      push_triangle(100, 100, 130, 100, 100, 130, npix);
      push_steps(npix);
      push_cmd(OP_CLEAR, 2'd0, '0, '0, '0, '0);
      push_triangle(100, 100, 130, 130, 160, 160, npix);
      push_steps(npix);
      push_triangle(200, 200, 206, 200, 200, 206, npix);
      push_steps(npix);
      drain();

      clears_left = 3;
      for (int phase = 0; phase < 6; phase++) begin
         csr_write(phase % 2 == 0);
         no_idle = (phase == 3);
         phase_items = 0;
         while (phase_items < 190) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               random_triangle(npix);
               npix = $urandom_range(0, 9) == 0 ? $urandom_range(0, npix) :
                      npix + $urandom_range(0, 2);
               push_steps(npix);
               phase_items += npix + 3;
            end else if (r < 87) begin
               push_cmd(OP_LOAD, $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
               push_steps($urandom_range(0, 2));
               phase_items += 2;
            end else if (r < 97) begin
               push_cmd(op_type'($urandom_range(0, 1) ? 2'd3 : 2'd1), $urandom_range(0, 3),
                        $urandom, $urandom, $urandom, $urandom);
            end else if (r < 98 && clears_left > 0) begin
               push_cmd(OP_CLEAR, $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom);
               clears_left--;
            end else begin
               push_cmd(OP_LOAD, SLOT_NONE, $urandom, $urandom, $urandom, $urandom);
            end
         end
         drain();
      end
      no_idle = 1'b0;

      $display("%0d items sent: %0d triangles, %0d clears, both sample modes", item_total,
               triangles, clears);
      $display("%0d pixel transfers checked, %0d of them written", pixels_seen, pixels_written);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d pixels never seen", mismatches, expected_pixels.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
